### rtl/core/ccfc_pkg.sv
package ccfc_pkg;

    typedef logic [1:0] t_fmt;

    localparam t_fmt FMT_BYTE  = 2'd0;
    localparam t_fmt FMT_SHORT = 2'd1;
    localparam t_fmt FMT_FLOAT = 2'd2;
    localparam t_fmt FMT_NONE  = 2'd3;

    localparam logic [1:0] CFG_SOURCE_FORMAT = 2'd0;
    localparam logic [1:0] CFG_TARGET_FORMAT = 2'd1;
    localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd2;

    localparam logic [31:0] FLOAT_ONE  = 32'h3F80_0000;
    localparam logic [31:0] BYTE_MAX   = 32'd255;
    localparam logic [31:0] SHORT_MAX  = 32'd65535;
    localparam logic [8:0]  FLOAT_BIAS_SHIFT = 9'd150;

    typedef struct packed {
        t_fmt       src;
        t_fmt       dst;
        logic [2:0] cnt;
    } t_cfg;

    function automatic logic [3:0] clz16(input logic [15:0] v);
        logic [3:0] n;
        logic       found;
        n     = 4'd0;
        found = 1'b0;
        for (int b = 15; b >= 0; b--) begin
            if (!found && v[b]) begin
                n     = 4'(15 - b);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

### rtl/core/ccfc_in_if.sv
interface ccfc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] chan_in_0;
    logic [31:0] chan_in_1;
    logic [31:0] chan_in_2;
    logic [31:0] chan_in_3;

    modport source (output valid, output chan_in_0, output chan_in_1,
                    output chan_in_2, output chan_in_3, input ready);
    modport sink   (input valid, input chan_in_0, input chan_in_1,
                    input chan_in_2, input chan_in_3, output ready);
endinterface

### rtl/core/ccfc_out_if.sv
interface ccfc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] chan_out_0;
    logic [31:0] chan_out_1;
    logic [31:0] chan_out_2;
    logic [31:0] chan_out_3;

    modport source (output valid, output chan_out_0, output chan_out_1,
                    output chan_out_2, output chan_out_3, input ready);
    modport sink   (input valid, input chan_out_0, input chan_out_1,
                    input chan_out_2, input chan_out_3, output ready);
endinterface

### rtl/core/ccfc_lane.sv
module ccfc_lane (
    input  logic             i_clk,
    input  ccfc_pkg::t_cfg   i_cfg,
    input  logic             i_en1,
    input  logic             i_en2,
    input  logic [31:0]      i_raw,
    output logic [31:0]      o_res
);

    logic [7:0]  v8;
    logic [15:0] v16;
    logic [15:0] p16;
    logic [3:0]  lz;
    logic [63:0] stream;
    logic [31:0] i2f;
    logic [24:0] s2b;
    logic [39:0] prod;
    logic [23:0] mant;
    logic        wide;

    logic [31:0] n_simple, r_simple;
    logic        n_f2i, r_f2i;
    logic        n_zero, r_zero;
    logic        n_sat, r_sat;
    logic [39:0] r_prod;
    logic [7:0]  r_exp;
    logic        r_wide;

    logic [4:0]  k;
    logic [39:0] keep;
    logic        rb;
    logic        sticky;
    logic [24:0] rnd;
    logic [8:0]  sh;
    logic [31:0] ival;
    logic [31:0] n_res, r_res;

    always_comb begin
        v8     = i_raw[7:0];
        v16    = i_raw[15:0];
        p16    = (i_cfg.src == ccfc_pkg::FMT_SHORT) ? v16 : {v8, v8};
        lz     = ccfc_pkg::clz16(p16);
        stream = {p16, p16, p16, p16} << lz;
        if (p16 == 16'd0) begin
            i2f = 32'd0;
        end else if (p16 == 16'hFFFF) begin
            i2f = ccfc_pkg::FLOAT_ONE;
        end else begin
            i2f = {1'b0, 8'(8'd126 - {4'd0, lz}), stream[62:40]} + 32'(stream[39]);
        end
        s2b  = ({9'd0, v16} << 8) - {9'd0, v16} + 25'd255;
        wide = (i_cfg.dst == ccfc_pkg::FMT_SHORT);
        mant = {1'b1, i_raw[22:0]};
        prod = wide ? (({16'd0, mant} << 16) - {16'd0, mant})
                    : (({16'd0, mant} << 8) - {16'd0, mant});

        n_f2i    = 1'b0;
        n_simple = 32'd0;
        priority if (i_cfg.src == ccfc_pkg::FMT_BYTE) begin
            priority if (i_cfg.dst == ccfc_pkg::FMT_BYTE) n_simple = {24'd0, v8};
            else if (i_cfg.dst == ccfc_pkg::FMT_SHORT)   n_simple = {16'd0, v8, v8};
            else                                          n_simple = i2f;
        end else if (i_cfg.src == ccfc_pkg::FMT_SHORT) begin
            priority if (i_cfg.dst == ccfc_pkg::FMT_BYTE) n_simple = {24'd0, s2b[23:16]};
            else if (i_cfg.dst == ccfc_pkg::FMT_SHORT)   n_simple = {16'd0, v16};
            else                                          n_simple = i2f;
        end else begin
            priority if (i_cfg.dst == ccfc_pkg::FMT_BYTE || i_cfg.dst == ccfc_pkg::FMT_SHORT)
                n_f2i = 1'b1;
            else
                n_simple = i_raw;
        end

        n_zero = i_raw[31] || (i_raw[30:23] == 8'd0)
              || ((i_raw[30:23] == 8'hFF) && (i_raw[22:0] != 23'd0));
        n_sat  = (i_raw[30:0] >= ccfc_pkg::FLOAT_ONE[30:0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en1) begin
            r_simple <= n_simple;
            r_f2i    <= n_f2i;
            r_zero   <= n_zero;
            r_sat    <= n_sat;
            r_prod   <= prod;
            r_exp    <= i_raw[30:23];
            r_wide   <= wide;
        end
    end

    always_comb begin
        if (r_wide) k = r_prod[39] ? 5'd16 : 5'd15;
        else        k = r_prod[31] ? 5'd8 : 5'd7;
        keep   = r_prod >> k;
        rb     = r_prod[k - 5'd1];
        sticky = |(r_prod & ((40'd1 << (k - 5'd1)) - 40'd1));
        rnd    = {1'b0, keep[23:0]} + 25'(rb && (sticky || keep[0]));
        sh     = ccfc_pkg::FLOAT_BIAS_SHIFT - {1'b0, r_exp} - {4'd0, k};
        ival   = (sh > 9'd24) ? 32'd0 : 32'(rnd >> sh);
        if (!r_f2i)      n_res = r_simple;
        else if (r_zero) n_res = 32'd0;
        else if (r_sat)  n_res = r_wide ? ccfc_pkg::SHORT_MAX : ccfc_pkg::BYTE_MAX;
        else             n_res = ival;
    end

    always_ff @(posedge i_clk) begin
        if (i_en2) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

### rtl/core/ccfc_merge.sv
module ccfc_merge #(
    parameter int CHANNELS = 4
) (
    input  ccfc_pkg::t_cfg i_cfg,
    input  logic [31:0]    i_lane [4],
    output logic [31:0]    o_chan [4]
);

    logic [2:0] eff;
    logic       bad;

    always_comb begin
        eff = (i_cfg.cnt > 3'(CHANNELS)) ? 3'(CHANNELS) : i_cfg.cnt;
        bad = (i_cfg.src == ccfc_pkg::FMT_NONE) || (i_cfg.dst == ccfc_pkg::FMT_NONE);
        for (int c = 0; c < 4; c++) begin
            o_chan[c] = (!bad && (3'(c) < eff)) ? i_lane[c] : 32'd0;
        end
    end

endmodule

### rtl/core/color_channel_format_convert_core.sv
// Color channel format converter, one pixel per request.
// Input channel i_in carries four raw 32-bit channels; output channel o_out
// carries four converted channels. Both use valid/ready; a request moves on
// a clock edge with valid and ready high.
// Configuration: pulse i_cfg_we with i_cfg_idx 0 (source format), 1 (target
// format) or 2 (channel count) and the value on i_cfg_wdata. Write only
// while no request is in flight.
// An accepted request is registered in the first stage, then in the second,
// whose valid drives o_out.valid. Throughput: one pixel per cycle while
// o_out is not stalled; each channel has its own lane with a two-stage
// pipeline (decode/scale product, then rounding and truncation).
// Reset (i_rst_n low, synchronous): pipeline emptied, source and target
// format byte, channel count four.
// Stall: when o_out.ready is low the output holds; the pipeline keeps
// accepting until both stages are full, then i_in.ready drops.
module color_channel_format_convert_core #(
    parameter int CHANNELS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [2:0]        i_cfg_wdata,
    ccfc_in_if.sink           i_in,
    ccfc_out_if.source        o_out
);

    ccfc_pkg::t_cfg r_cfg;
    logic           r_v1, r_v2;
    logic           en1, en2;
    logic [31:0]    raw  [4];
    logic [31:0]    lane [4];
    logic [31:0]    chan [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src <= ccfc_pkg::FMT_BYTE;
            r_cfg.dst <= ccfc_pkg::FMT_BYTE;
            r_cfg.cnt <= 3'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ccfc_pkg::CFG_SOURCE_FORMAT: r_cfg.src <= i_cfg_wdata[1:0];
                ccfc_pkg::CFG_TARGET_FORMAT: r_cfg.dst <= i_cfg_wdata[1:0];
                ccfc_pkg::CFG_CHANNEL_COUNT: r_cfg.cnt <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign en2 = !r_v2 || o_out.ready;
    assign en1 = !r_v1 || en2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in.valid;
            if (en2) r_v2 <= r_v1;
        end
    end

    assign raw[0] = i_in.chan_in_0;
    assign raw[1] = i_in.chan_in_1;
    assign raw[2] = i_in.chan_in_2;
    assign raw[3] = i_in.chan_in_3;

    for (genvar g = 0; g < 4; g++) begin : g_lane
        if (g < CHANNELS) begin : g_on
            ccfc_lane u_lane (
                .i_clk (i_clk),
                .i_cfg (r_cfg),
                .i_en1 (en1),
                .i_en2 (en2),
                .i_raw (raw[g]),
                .o_res (lane[g])
            );
        end else begin : g_off
            assign lane[g] = 32'd0;
        end
    end

    ccfc_merge #(.CHANNELS(CHANNELS)) u_merge (
        .i_cfg  (r_cfg),
        .i_lane (lane),
        .o_chan (chan)
    );

    assign i_in.ready       = en1;
    assign o_out.valid      = r_v2;
    assign o_out.chan_out_0 = chan[0];
    assign o_out.chan_out_1 = chan[1];
    assign o_out.chan_out_2 = chan[2];
    assign o_out.chan_out_3 = chan[3];

`ifndef ASSERT_OFF
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_v1)
        else $error("accepted request lost");
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_v2 && !o_out.ready |-> !i_in.ready)
        else $error("accepting while pipeline full");
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (r_cfg.src == ccfc_pkg::FMT_NONE || r_cfg.dst == ccfc_pkg::FMT_NONE)
        |-> o_out.chan_out_0 == 32'd0)
        else $error("unused format code gave nonzero channel");
`endif

endmodule
